[hdl/srf_pkg.sv]
// shared types and constants of the sliding rank filter
package srf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAX_WIN  = 32;
	localparam int IDX_W    = $clog2(MAX_WIN);
	localparam int LEN_W    = 6;
	localparam int RANK_W   = 5;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(3);
	localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_RANK          = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [LEN_W-1:0]  window_length;
		logic [RANK_W-1:0] rank;
	} cfg_t;

	// value travelling around the ring with its history slot and window flag
	typedef struct packed {
		sample_t          value;
		logic [IDX_W-1:0] idx;
		logic             in_win;
	} probe_t;

	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_SELECT
	} state_t;

endpackage

[hdl/srf_cell.sv]
// one history slot: holds a sample and counts the window samples ranked below it
module srf_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srf_pkg::cell_ctrl_t             ctrl,
	input  logic [srf_pkg::IDX_W-1:0]       cell_idx,
	input  logic [srf_pkg::LEN_W-1:0]       win_len,
	input  logic [srf_pkg::RANK_W-1:0]      sel_rank,
	input  srf_pkg::sample_t                hist_in,
	input  srf_pkg::probe_t                 probe_in,
	output srf_pkg::sample_t                hist_out,
	output srf_pkg::probe_t                 probe_out,
	output logic                            hit
);
	import srf_pkg::*;

	sample_t           hist_q;
	probe_t            probe_q;
	logic [IDX_W-1:0]  count_q;
	logic              own_in_win;
	logic              ranks_below;

	assign own_in_win = {1'b0, cell_idx} < win_len;

	// equal values are ordered by history slot, newer first
	assign ranks_below = probe_q.in_win &&
		((probe_q.value < hist_q) || ((probe_q.value == hist_q) && (probe_q.idx < cell_idx)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctrl.load) begin
			hist_q <= hist_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			probe_q <= '{value: hist_in, idx: cell_idx, in_win: own_in_win};
			count_q <= '0;
		end else if (ctrl.step) begin
			probe_q <= probe_in;
			if (ranks_below) begin
				count_q <= count_q + IDX_W'(1);
			end
		end
	end

	assign hist_out  = hist_q;
	assign probe_out = probe_q;
	assign hit       = own_in_win && (count_q == sel_rank);

endmodule

[hdl/srf_apb_regs.sv]
// configuration registers behind the apb port
module srf_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srf_pkg::ADDR_W-1:0]   paddr,
	input  logic [srf_pkg::DATA_W-1:0]   pwdata,
	output logic [srf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output srf_pkg::cfg_t                cfg
);
	import srf_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length <= LEN_RESET;
			cfg_q.rank          <= RANK_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WINDOW_LENGTH: cfg_q.window_length <= pwdata[LEN_W-1:0];
				REG_RANK:          cfg_q.rank          <= pwdata[RANK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.window_length};
			REG_RANK:          prdata = {{(DATA_W-RANK_W){1'b0}}, cfg_q.rank};
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[hdl/sliding_rank_filter.sv]
// sliding-window rank filter: top level with cell chain, control and output register
// a sample is loaded into the cell chain, ranked while the probes make a full pass
//   around the ring, then picked into the output register; no new sample is taken
//   before the select state has handed its result on to the output register
// a finished result may wait in the output register while the next sample is taken
// reset: history slots cleared to zero, window_length 3, rank 1, no result pending
module sliding_rank_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srf_pkg::ADDR_W-1:0]   paddr,
	input  logic [srf_pkg::DATA_W-1:0]   pwdata,
	output logic [srf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  srf_pkg::sample_t             sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output srf_pkg::sample_t             filtered
);
	import srf_pkg::*;

	cfg_t             cfg;
	state_t           state_q, state_nxt;
	logic [IDX_W-1:0] step_q;
	cell_ctrl_t       cell_ctrl;
	logic             out_load;
	logic             out_valid_q;
	sample_t          filtered_q;

	logic [LEN_W-1:0]  len_eff;
	logic [RANK_W-1:0] rank_eff;

	sample_t hist   [MAX_WIN];
	probe_t  probe  [MAX_WIN];
	logic    hit    [MAX_WIN];
	sample_t picked;

	// configuration port
	srf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective window length: zero means one, above the store size means the store size
	always_comb begin
		if (cfg.window_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg.window_length > LEN_W'(MAX_WIN)) begin
			len_eff = LEN_W'(MAX_WIN);
		end else begin
			len_eff = cfg.window_length;
		end
	end

	// rank beyond the window picks the largest
	always_comb begin
		if ({1'b0, cfg.rank} >= len_eff) begin
			rank_eff = RANK_W'(len_eff - LEN_W'(1));
		end else begin
			rank_eff = cfg.rank;
		end
	end

	// cell chain: history shifts toward higher slots on a transfer,
	// probes rotate toward lower slots during the ranking pass
	for (genvar k = 0; k < MAX_WIN; k++) begin : g_cell
		sample_t hist_in;
		probe_t  probe_in;

		if (k == 0) begin : g_head
			assign hist_in = sample;
		end else begin : g_body
			assign hist_in = hist[k-1];
		end

		assign probe_in = probe[(k + 1) % MAX_WIN];

		srf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.cell_idx  (IDX_W'(k)),
			.win_len   (len_eff),
			.sel_rank  (rank_eff),
			.hist_in   (hist_in),
			.probe_in  (probe_in),
			.hist_out  (hist[k]),
			.probe_out (probe[k]),
			.hit       (hit[k])
		);
	end

	// exactly one window cell holds the requested rank
	always_comb begin
		picked = '0;
		for (int k = 0; k < MAX_WIN; k++) begin
			picked = picked | (hist[k] & {SAMPLE_W{hit[k]}});
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_RANK;
			end
			ST_RANK: begin
				if (step_q == IDX_W'(MAX_WIN - 1)) state_nxt = ST_SELECT;
			end
			ST_SELECT: begin
				if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready       = 1'b0;
		cell_ctrl.load = 1'b0;
		cell_ctrl.step = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cell_ctrl.load = in_valid;
			end
			ST_RANK: begin
				cell_ctrl.step = 1'b1;
			end
			ST_SELECT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cell_ctrl.step) begin
				step_q <= step_q + IDX_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// output register, holds until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= picked;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule
